### hw/rtl/psrtd_pkg.sv
// Shared types, constants and helpers for the per-source rate threshold detector.
`default_nettype none
package psrtd_pkg;

    // Table size and count width
    localparam int SOURCES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = $clog2(SOURCES);
    localparam int USED_W     = $clog2(SOURCES + 1);

    // Request codes
    localparam logic [1:0] REQ_PKT   = 2'd0;
    localparam logic [1:0] REQ_EVAL  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_COUNTED = 3'd0;
    localparam logic [2:0] KIND_NEW     = 3'd1;
    localparam logic [2:0] KIND_FULL    = 3'd2;
    localparam logic [2:0] KIND_ALERT   = 3'd3;
    localparam logic [2:0] KIND_DONE    = 3'd4;

    // Compare unit operations
    localparam logic CMP_EQ = 1'b0;
    localparam logic CMP_GT = 1'b1;

    // Configuration register indexes
    localparam logic REG_COUNT_LIMIT   = 1'b0;
    localparam logic REG_DETECT_ENABLE = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] source_addr;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] result_addr;
        logic [3:0]  entry_index;
        logic [15:0] window_count;
        logic [4:0]  flagged_total;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [15:0] count_limit;
        logic        detect_enable;
    } cfg_t;

    // Output field views of internal values (masked as the result fields are)
    function automatic logic [15:0] count_field(input logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[15:0];
    endfunction

    function automatic logic [3:0] index_field(input logic [IDX_W-1:0] i);
        logic [31:0] w;
        w = 32'(i);
        return w[3:0];
    endfunction

    function automatic logic [4:0] total_field(input logic [USED_W-1:0] t);
        logic [31:0] w;
        w = 32'(t);
        return w[4:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/psrtd_cmp.sv
// Shared compare unit: address equality or count-above-limit test.
`default_nettype none
module psrtd_cmp
    import psrtd_pkg::*;
(
    input  wire logic        op,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             hit
);

    // One 32-bit comparator serves both the lookup and the evaluate scans
    always_comb
    begin
        case (op)
            CMP_EQ:  hit = (a == b);
            CMP_GT:  hit = (a > b);
            default: hit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/psrtd_cfg.sv
// APB-style configuration registers: count limit and detect enable.
`default_nettype none
module psrtd_cfg
    import psrtd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic        wr_en;
    logic        reg_sel;
    logic [15:0] count_limit_reg;
    logic        detect_enable_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_limit_reg   <= 16'd6;
            detect_enable_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_COUNT_LIMIT)
                count_limit_reg <= pwdata[15:0];
            else
                detect_enable_reg <= pwdata[0];
        end
    end

    // Read back
    always_comb
    begin
        if (reg_sel == REG_COUNT_LIMIT)
            prdata = {16'd0, count_limit_reg};
        else
            prdata = {31'd0, detect_enable_reg};
    end

    assign cfg.count_limit   = count_limit_reg;
    assign cfg.detect_enable = detect_enable_reg;

endmodule
`default_nettype wire

### hw/rtl/per_source_rate_threshold_detector.sv
// Top level: source table, scan sequencer and result register of the rate detector.
// Packet word: accepted in S_IDLE, then table slots are scanned in order (1..SOURCES of them) by the
//   shared comparator in S_LOOK, result registered on the last scan cycle.
// Evaluate tick: all SOURCES slots are scanned, then done (no scan if detect is off); clear: straight to done.
// One word is in work at a time; a result stall holds the scan on a slot that must emit a result.
// Reset (rst_n, asynchronous) empties the table, zeroes counts, flags and totals,
// and sets count_limit to 6 and detect_enable to 1. Stored addresses are not reset.
`default_nettype none
module per_source_rate_threshold_detector
    import psrtd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire in_word_t    req,
    output logic             res_valid,
    input  wire logic        res_stall,
    output out_word_t        res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [IDX_W-1:0]      SCAN_LAST = IDX_W'(SOURCES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    cfg_t cfg;

    logic [1:0]            state_reg, state_next;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic [31:0]           addr_reg, addr_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic [USED_W-1:0]     flagged_count_reg, flagged_count_next;
    logic [SOURCES-1:0]    valid_reg, valid_next;
    logic [SOURCES-1:0]    flagged_reg, flagged_next;
    logic [COUNT_BITS-1:0] count_reg [SOURCES];
    logic [COUNT_BITS-1:0] count_next [SOURCES];
    logic [31:0]           entry_addr_reg [SOURCES];
    logic                  res_valid_reg, res_valid_next;
    out_word_t             res_reg, res_next;

    logic                  addr_we;
    logic [IDX_W-1:0]      addr_wa;
    logic                  cmp_op;
    logic [31:0]           cmp_a, cmp_b;
    logic                  cmp_hit;
    logic                  out_free;
    logic                  accept;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic                  cur_valid;

    psrtd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Shared comparator operand selection
    assign cur_count = count_reg[scan_reg];
    assign cur_valid = valid_reg[scan_reg];
    assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

    always_comb
    begin
        if (state_reg == S_EVAL)
        begin
            cmp_op = CMP_GT;
            cmp_a  = 32'(cur_count);
            cmp_b  = 32'(cfg.count_limit);
        end
        else
        begin
            cmp_op = CMP_EQ;
            cmp_a  = addr_reg;
            cmp_b  = entry_addr_reg[scan_reg];
        end
    end

    psrtd_cmp u_cmp (
        .op  (cmp_op),
        .a   (cmp_a),
        .b   (cmp_b),
        .hit (cmp_hit)
    );

    assign out_free  = !res_valid_reg || !res_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        scan_next          = scan_reg;
        addr_next          = addr_reg;
        used_next          = used_reg;
        flagged_count_next = flagged_count_reg;
        valid_next         = valid_reg;
        flagged_next       = flagged_reg;
        count_next         = count_reg;
        res_valid_next     = res_valid_reg && res_stall;
        res_next           = res_reg;
        addr_we            = 1'b0;
        addr_wa            = used_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_next = req.source_addr;
                    scan_next = '0;
                    case (req.req_type)
                        REQ_PKT:   state_next = S_LOOK;
                        REQ_EVAL:  state_next = cfg.detect_enable ? S_EVAL : S_DONE;
                        REQ_CLEAR: state_next = S_DONE;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end

            S_LOOK:
            begin
                if (cur_valid && cmp_hit)
                begin
                    // known source: count it
                    if (out_free)
                    begin
                        count_next[scan_reg]     = inc_count;
                        res_valid_next           = 1'b1;
                        res_next.result_kind     = KIND_COUNTED;
                        res_next.result_addr     = addr_reg;
                        res_next.entry_index     = index_field(scan_reg);
                        res_next.window_count    = count_field(inc_count);
                        res_next.flagged_total   = total_field(flagged_count_reg);
                        res_next.last            = 1'b1;
                        state_next               = S_IDLE;
                    end
                end
                else if (!cur_valid || scan_reg == SCAN_LAST)
                begin
                    // not found: learn it, or drop it when the table is full
                    if (out_free)
                    begin
                        res_valid_next         = 1'b1;
                        res_next.result_addr   = addr_reg;
                        res_next.flagged_total = total_field(flagged_count_reg);
                        res_next.last          = 1'b1;
                        state_next             = S_IDLE;
                        if (used_reg < USED_W'(SOURCES))
                        begin
                            addr_we                               = 1'b1;
                            valid_next[used_reg[IDX_W-1:0]]       = 1'b1;
                            flagged_next[used_reg[IDX_W-1:0]]     = 1'b0;
                            count_next[used_reg[IDX_W-1:0]]       = COUNT_BITS'(1);
                            used_next                             = used_reg + 1'b1;
                            res_next.result_kind                  = KIND_NEW;
                            res_next.entry_index    = index_field(used_reg[IDX_W-1:0]);
                            res_next.window_count   = 16'd1;
                        end
                        else
                        begin
                            res_next.result_kind  = KIND_FULL;
                            res_next.entry_index  = 4'd0;
                            res_next.window_count = 16'd0;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_EVAL:
            begin
                if (cur_valid && !flagged_reg[scan_reg] && cmp_hit)
                begin
                    // newly over the limit: flag and alert
                    if (out_free)
                    begin
                        flagged_next[scan_reg] = 1'b1;
                        flagged_count_next     = flagged_count_reg + 1'b1;
                        res_valid_next         = 1'b1;
                        res_next.result_kind   = KIND_ALERT;
                        res_next.result_addr   = entry_addr_reg[scan_reg];
                        res_next.entry_index   = index_field(scan_reg);
                        res_next.window_count  = count_field(cur_count);
                        res_next.flagged_total = total_field(flagged_count_reg + 1'b1);
                        res_next.last          = 1'b0;
                        scan_next              = scan_reg + 1'b1;
                        if (scan_reg == SCAN_LAST)
                            state_next = S_DONE;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    if (scan_reg == SCAN_LAST)
                        state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // window done, counts cleared
                if (out_free)
                begin
                    for (int i = 0; i < SOURCES; i++)
                        count_next[i] = '0;
                    res_valid_next         = 1'b1;
                    res_next.result_kind   = KIND_DONE;
                    res_next.result_addr   = 32'd0;
                    res_next.entry_index   = 4'd0;
                    res_next.window_count  = 16'd0;
                    res_next.flagged_total = total_field(flagged_count_reg);
                    res_next.last          = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            scan_reg          <= '0;
            used_reg          <= '0;
            flagged_count_reg <= '0;
            valid_reg         <= '0;
            flagged_reg       <= '0;
            res_valid_reg     <= 1'b0;
            for (int i = 0; i < SOURCES; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            scan_reg          <= scan_next;
            used_reg          <= used_next;
            flagged_count_reg <= flagged_count_next;
            valid_reg         <= valid_next;
            flagged_reg       <= flagged_next;
            res_valid_reg     <= res_valid_next;
            count_reg         <= count_next;
        end
    end

    // Payload: latched address, stored addresses, result word
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        res_reg  <= res_next;
        if (addr_we)
            entry_addr_reg[addr_wa] <= addr_reg;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire
